>>> rtl/core/ip6tv_pkg.sv
package ip6tv_pkg;

    // Phase codes
    localparam logic [1:0] PH_LEAD  = 2'd0;  // leading whitespace of address
    localparam logic [1:0] PH_ADDR  = 2'd1;  // address body
    localparam logic [1:0] PH_ZLEAD = 2'd2;  // leading whitespace of zone
    localparam logic [1:0] PH_ZONE  = 2'd3;  // zone body

    // Verdict codes
    localparam logic [1:0] VERDICT_VALID    = 2'd0;
    localparam logic [1:0] VERDICT_REQUIRED = 2'd1;
    localparam logic [1:0] VERDICT_BAD_ADDR = 2'd2;
    localparam logic [1:0] VERDICT_BAD_ZONE = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [8:0] OCTET_MAX = 9'd255;
    localparam logic [8:0] OCTET_SAT = 9'd256;
    localparam logic [3:0] GROUPS_FULL = 4'd8;
    localparam logic [3:0] GROUPS_COMP = 4'd7;

    typedef struct packed {
        logic [1:0] phase;
        logic       pending_blank;
        logic       addr_seen;
        logic       addr_fault;
        logic       colon_seen;
        logic [1:0] colon_run;
        logic       compressed_seen;
        logic [3:0] group_count;
        logic [2:0] part_length;
        logic       part_has_dot;
        logic       part_has_letter;
        logic [8:0] octet_value;
        logic [2:0] octet_digits;
        logic [2:0] octet_count;
        logic [4:0] zone_length;
        logic       zone_prev_dot;
        logic       zone_fault;
    } state_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [2:0] sat_inc3(input logic [2:0] v);
        return (v == 3'd7) ? v : v + 3'd1;
    endfunction

    function automatic logic octet_ok(input state_t s);
        return s.octet_digits >= 3'd1 && s.octet_digits <= 3'd3 && s.octet_value <= OCTET_MAX;
    endfunction

    // Close one colon-separated part and count its groups
    function automatic state_t close_part(input state_t s);
        state_t     r;
        logic [1:0] add;
        logic [4:0] sum;
        r   = s;
        add = 2'd0;
        if (r.part_has_dot) begin
            if (!r.part_has_letter && r.octet_count == 3'd3 && octet_ok(r)) begin
                add = 2'd2;
            end else begin
                r.addr_fault = 1'b1;
            end
        end else if (r.part_length >= 3'd1 && r.part_length <= 3'd4) begin
            add = 2'd1;
        end else begin
            r.addr_fault = 1'b1;
        end
        sum = {1'b0, r.group_count} + {3'b0, add};
        r.group_count     = sum[4] ? 4'd15 : sum[3:0];
        r.part_length     = '0;
        r.part_has_dot    = 1'b0;
        r.part_has_letter = 1'b0;
        r.octet_value     = '0;
        r.octet_digits    = '0;
        r.octet_count     = '0;
        return r;
    endfunction

    // End of the address: close the last part and check group totals
    function automatic state_t addr_finish(input state_t s);
        state_t r;
        r = s;
        if (r.colon_run == 2'd0) begin
            r = close_part(r);
        end else if (r.colon_run == 2'd1) begin
            r.addr_fault = 1'b1;
        end
        if (!r.colon_seen) begin
            r.addr_fault = 1'b1;
        end
        if (r.compressed_seen) begin
            if (r.group_count > GROUPS_COMP) begin
                r.addr_fault = 1'b1;
            end
        end else if (r.group_count != GROUPS_FULL) begin
            r.addr_fault = 1'b1;
        end
        return r;
    endfunction

    // One non-blank character of the address body
    function automatic state_t addr_char(input state_t s, input logic [7:0] c);
        state_t      r;
        logic [11:0] v;
        r = s;
        v = ({3'b0, r.octet_value} * 12'd10) + {8'b0, c[3:0]};
        if (r.pending_blank) begin
            r.addr_fault    = 1'b1;
            r.pending_blank = 1'b0;
        end
        r.addr_seen = 1'b1;
        if (c == CH_COLON) begin
            r.colon_seen = 1'b1;
            if (r.colon_run == 2'd0) begin
                if (r.part_length != 3'd0) begin
                    r = close_part(r);
                end
                r.colon_run = 2'd1;
            end else if (r.colon_run == 2'd1) begin
                if (r.compressed_seen) begin
                    r.addr_fault = 1'b1;
                end
                r.compressed_seen = 1'b1;
                r.colon_run       = 2'd2;
            end else begin
                r.addr_fault = 1'b1;
                r.colon_run  = 2'd3;
            end
        end else begin
            // a single leading colon is a fault
            if (r.colon_run == 2'd1 && r.group_count == 4'd0 && !r.compressed_seen) begin
                r.addr_fault = 1'b1;
            end
            r.colon_run = 2'd0;
            if (is_dec(c)) begin
                r.octet_value  = (v > {3'b0, OCTET_SAT}) ? OCTET_SAT : v[8:0];
                r.octet_digits = sat_inc3(r.octet_digits);
                r.part_length  = sat_inc3(r.part_length);
            end else if (is_hex_letter(c)) begin
                r.part_has_letter = 1'b1;
                r.part_length     = sat_inc3(r.part_length);
            end else if (c == CH_DOT) begin
                if (!octet_ok(r)) begin
                    r.addr_fault = 1'b1;
                end
                r.octet_count  = sat_inc3(r.octet_count);
                r.part_has_dot = 1'b1;
                r.octet_value  = '0;
                r.octet_digits = '0;
                r.part_length  = sat_inc3(r.part_length);
            end else begin
                r.addr_fault = 1'b1;
            end
        end
        return r;
    endfunction

    // One non-blank character of the zone body
    function automatic state_t zone_char(input state_t s, input logic [7:0] c,
                                         input logic [4:0] max_len);
        state_t r;
        r = s;
        if (r.pending_blank) begin
            r.zone_fault    = 1'b1;
            r.pending_blank = 1'b0;
        end
        if (r.zone_length == 5'd0 && !is_alpha(c)) begin
            r.zone_fault = 1'b1;
        end
        if (r.zone_length >= max_len) begin
            r.zone_fault = 1'b1;
        end
        r.zone_length = (r.zone_length == 5'd31) ? r.zone_length : r.zone_length + 5'd1;
        if (!(is_alpha(c) || is_dec(c) || c == CH_UNDER || c == CH_DASH || c == CH_DOT)) begin
            r.zone_fault = 1'b1;
        end
        if (c == CH_DOT && r.zone_prev_dot) begin
            r.zone_fault = 1'b1;
        end
        r.zone_prev_dot = (c == CH_DOT);
        return r;
    endfunction

endpackage

>>> rtl/core/ip6tv_step.sv
module ip6tv_step #(
    parameter int MAX_ZONE_CHARS = 15
) (
    input  ip6tv_pkg::state_t st_i,
    input  logic              has_char,
    input  logic [7:0]        char_byte,
    input  logic              accept_blank,
    output ip6tv_pkg::state_t st_o,
    output logic [1:0]        verdict
);
    import ip6tv_pkg::*;

    localparam logic [4:0] ZONE_MAX = 5'(MAX_ZONE_CHARS);

    state_t s;
    state_t fin;

    // Per-character state update
    always_comb begin
        s = st_i;
        if (has_char) begin
            unique case (s.phase)
                PH_LEAD: begin
                    if (!is_blank(char_byte)) begin
                        if (char_byte == CH_PERCENT) begin
                            s.phase = PH_ZLEAD;
                        end else begin
                            s.phase = PH_ADDR;
                            s = addr_char(s, char_byte);
                        end
                    end
                end
                PH_ADDR: begin
                    if (is_blank(char_byte)) begin
                        s.pending_blank = 1'b1;
                    end else if (char_byte == CH_PERCENT) begin
                        if (s.pending_blank) begin
                            s.addr_fault = 1'b1;
                        end
                        s.pending_blank = 1'b0;
                        s = addr_finish(s);
                        s.phase = PH_ZLEAD;
                    end else begin
                        s = addr_char(s, char_byte);
                    end
                end
                PH_ZLEAD: begin
                    if (!is_blank(char_byte)) begin
                        s.phase = PH_ZONE;
                        s = zone_char(s, char_byte, ZONE_MAX);
                    end
                end
                PH_ZONE: begin
                    if (is_blank(char_byte)) begin
                        s.pending_blank = 1'b1;
                    end else begin
                        s = zone_char(s, char_byte, ZONE_MAX);
                    end
                end
            endcase
        end
    end

    // Verdict as if the text ended here; a missing address comes first, then zone faults
    always_comb begin
        fin = addr_finish(s);
        unique case (s.phase)
            PH_LEAD: verdict = accept_blank ? VERDICT_VALID : VERDICT_REQUIRED;
            PH_ADDR: verdict = fin.addr_fault ? VERDICT_BAD_ADDR : VERDICT_VALID;
            PH_ZLEAD, PH_ZONE: begin
                if (!s.addr_seen) begin
                    verdict = VERDICT_BAD_ADDR;
                end else if (s.zone_fault || s.zone_length == 5'd0) begin
                    verdict = VERDICT_BAD_ZONE;
                end else begin
                    verdict = s.addr_fault ? VERDICT_BAD_ADDR : VERDICT_VALID;
                end
            end
        endcase
    end

    assign st_o = s;

endmodule

>>> rtl/core/ipv6_text_validator.sv
// IPv6 address text validator. Text enters one byte per transaction on the
// s_ channel (s_tuser = byte present, s_tlast = end of text); the last
// transaction yields one verdict on the m_ channel: 0 valid, 1 address
// required, 2 invalid address, 3 invalid zone id, plus an is_valid bit.
// Throughput is one byte per clock with no gaps between texts while verdicts
// are read; a byte is processed from the input register, and the verdict of
// an end-of-text byte is registered in the output register that drives
// m_tvalid once that byte is processed. s_tready drops only while
// an end-of-text byte waits behind an unread verdict with m_tready low.
// cfg_data bit 0 (accept_blank) makes blank text valid; write it while idle.
module ipv6_text_validator #(
    parameter int MAX_ZONE_CHARS = 15
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tuser,   // [0] has_char
    input  logic       s_tlast,   // end_of_text
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] verdict, [2] is_valid, [7:3] zero
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data   // accept_blank
);
    import ip6tv_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_has_reg;
    logic       in_last_reg;
    logic       accept_blank_reg;
    state_t     st_reg;
    state_t     st_next;
    logic [1:0] verdict_next;
    logic       out_valid_reg;
    logic [1:0] out_verdict_reg;
    logic       fire;

    // Process the held byte unless its verdict would overwrite an unread one
    assign fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_blank_reg <= 1'b0;
        end else if (cfg_valid) begin
            accept_blank_reg <= cfg_data;
        end
    end

    ip6tv_step #(
        .MAX_ZONE_CHARS (MAX_ZONE_CHARS)
    ) u_step (
        .st_i         (st_reg),
        .has_char     (in_has_reg),
        .char_byte    (in_char_reg),
        .accept_blank (accept_blank_reg),
        .st_o         (st_next),
        .verdict      (verdict_next)
    );

    // Parse state; cleared after each verdict
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (fire) begin
            st_reg <= in_last_reg ? '0 : st_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_last_reg) begin
            out_verdict_reg <= verdict_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, (out_verdict_reg == VERDICT_VALID), out_verdict_reg};

endmodule

>>> sim/tb.sv
module tb;
    import ip6tv_pkg::*;

    localparam int ZONE_MAX      = 15;
    localparam int NONE          = -1;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 500;

    // character classes seen by the scanner
    typedef enum logic [3:0] {
        CC_BLANK, CC_DIGIT, CC_HEXLET, CC_LETTER, CC_COLON,
        CC_DOT, CC_PCT, CC_MARK, CC_OTHER
    } char_class_t;

    // running scan state of one text
    typedef struct packed {
        logic [1:0] phase;
        logic       gap_blank;
        logic       body_seen;
        logic       addr_bad;
        logic       any_colon;
        logic [1:0] colons;
        logic       dbl_colon;
        logic [3:0] groups;
        logic [2:0] part_len;
        logic       part_dot;
        logic       part_alpha;
        logic [8:0] oct_val;
        logic [2:0] oct_digs;
        logic [2:0] oct_cnt;
        logic [4:0] zone_len;
        logic       zone_dot;
        logic       zone_bad;
    } scan_t;

    typedef struct {
        logic [1:0] code;
        logic       ok;
        int         tag;
    } verdict_rec_t;

    typedef struct {
        string txt;
        bit    alone;
        int    cfg_wr;
        int    pinned;
    } row_t;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tuser   = 1'b0;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    scan_t          sc = '0;
    logic           blank_ok = 1'b0;
    verdict_rec_t   verdict_q[$];
    logic [7:0]     text_q[$];
    int             pinned_verdict = NONE;
    int             texts_done = 0;
    int             items_sent = 0;
    int             errors = 0;
    int             cycle_count = 0;
    int             holds_asked = 0;
    int             holds_taken = 0;
    bit             no_idle = 1'b0;
    bit             noise_items = 1'b0;
    string          hexset = "0123456789abcdefABCDEF";
    string          picks  = "0123456789abcdefABCDEF:.%_- gGz\011";
    string          zset   = "abcxyzABXYZ0189_-.";
    string          lead   = "aAbzZqeth";

    row_t dir_rows[28] = '{
        '{"", 1'b1, NONE, VERDICT_REQUIRED},
        '{" \011\012\013\014\015", 1'b1, 1, VERDICT_VALID},
        '{"  ::1  ", 1'b0, NONE, VERDICT_VALID},
        '{"1:2:3:4:5:6:7:8", 1'b0, NONE, VERDICT_VALID},
        '{"FFFF:ffff:0:0:0:0:0:0", 1'b0, NONE, NONE},
        '{"::ffff:255.255.255.255", 1'b0, NONE, NONE},
        '{"1.2.3.4::", 1'b0, NONE, NONE},
        '{"1:2:3:4:5:6:7:8:9", 1'b0, NONE, NONE},
        '{"1::2::3", 1'b0, NONE, NONE},
        '{":1:2:3:4:5:6:7", 1'b0, NONE, NONE},
        '{"1:2:3:4:5:6:7:", 1'b0, NONE, NONE},
        '{"12345::", 1'b0, NONE, NONE},
        '{"::256.0.0.1", 1'b0, NONE, NONE},
        '{"1 2::3", 1'b0, NONE, NONE},
        '{"::1:::2", 1'b0, NONE, NONE},
        '{"%eth0", 1'b0, NONE, VERDICT_BAD_ADDR},
        '{"fe80::1%eth0", 1'b0, NONE, NONE},
        '{" fe80::1%  eth0.1_a-B  ", 1'b0, NONE, NONE},
        '{"fe80::1%0eth", 1'b0, NONE, VERDICT_BAD_ZONE},
        '{"fe80::1%", 1'b0, NONE, VERDICT_BAD_ZONE},
        '{"fe80::1%abcdefghijklmnop", 1'b0, NONE, NONE},
        '{"fe80::1%abcdefghijklmno", 1'b0, NONE, NONE},
        '{"zz%a..b", 1'b0, NONE, VERDICT_BAD_ZONE},
        '{"fe80::1%a%b", 1'b0, NONE, NONE},
        '{"fe80::1%a b", 1'b0, NONE, NONE},
        '{"\200::\377", 1'b0, NONE, NONE},
        '{"1:2:3:4:5:6:7:8", 1'b1, 0, NONE},
        '{"\011 ", 1'b1, NONE, VERDICT_REQUIRED}
    };

    ipv6_text_validator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] char_byte
        .s_tuser   (s_tuser),   // [0] has_char
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [1:0] verdict, [2] is_valid
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // verdict predictor
    // ---------------------------------------------------------------
    function automatic char_class_t char_class(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) return CC_BLANK;
        if (c >= 8'h30 && c <= 8'h39) return CC_DIGIT;
        if (lc >= 8'h61 && lc <= 8'h66) return CC_HEXLET;
        if (lc >= 8'h67 && lc <= 8'h7A) return CC_LETTER;
        if (c == CH_COLON) return CC_COLON;
        if (c == CH_DOT) return CC_DOT;
        if (c == CH_PERCENT) return CC_PCT;
        if (c == CH_UNDER || c == CH_DASH) return CC_MARK;
        return CC_OTHER;
    endfunction

    function automatic logic [2:0] bump7(input logic [2:0] v);
        return (v == 3'd7) ? v : v + 3'd1;
    endfunction

    function automatic logic octet_good();
        return sc.oct_digs >= 3'd1 && sc.oct_digs <= 3'd3 && sc.oct_val <= 9'd255;
    endfunction

    // one colon-separated part is complete: count one or two groups
    function automatic void close_group();
        int add;
        int sum;
        add = 0;
        if (sc.part_dot) begin
            if (!sc.part_alpha && sc.oct_cnt == 3'd3 && octet_good()) add = 2;
            else sc.addr_bad = 1'b1;
        end else if (sc.part_len >= 3'd1 && sc.part_len <= 3'd4) begin
            add = 1;
        end else begin
            sc.addr_bad = 1'b1;
        end
        sum = int'(sc.groups) + add;
        sc.groups     = (sum > 15) ? 4'd15 : 4'(sum);
        sc.part_len   = '0;
        sc.part_dot   = 1'b0;
        sc.part_alpha = 1'b0;
        sc.oct_val    = '0;
        sc.oct_digs   = '0;
        sc.oct_cnt    = '0;
    endfunction

    function automatic void finish_address();
        if (sc.colons == 2'd0) close_group();
        else if (sc.colons == 2'd1) sc.addr_bad = 1'b1;
        if (!sc.any_colon) sc.addr_bad = 1'b1;
        if (sc.dbl_colon) begin
            if (sc.groups > 4'd7) sc.addr_bad = 1'b1;
        end else if (sc.groups != 4'd8) begin
            sc.addr_bad = 1'b1;
        end
    endfunction

    function automatic void address_char(input logic [7:0] c, input char_class_t cls);
        int v;
        if (sc.gap_blank) begin
            sc.addr_bad  = 1'b1;
            sc.gap_blank = 1'b0;
        end
        sc.body_seen = 1'b1;
        if (cls == CC_COLON) begin
            sc.any_colon = 1'b1;
            case (sc.colons)
                2'd0: begin
                    if (sc.part_len != 3'd0) close_group();
                    sc.colons = 2'd1;
                end
                2'd1: begin
                    if (sc.dbl_colon) sc.addr_bad = 1'b1;
                    sc.dbl_colon = 1'b1;
                    sc.colons    = 2'd2;
                end
                default: begin
                    sc.addr_bad = 1'b1;
                    sc.colons   = 2'd3;
                end
            endcase
            return;
        end
        // a lone colon at the very start
        if (sc.colons == 2'd1 && sc.groups == 4'd0 && !sc.dbl_colon) sc.addr_bad = 1'b1;
        sc.colons = 2'd0;
        case (cls)
            CC_DIGIT: begin
                v = int'(sc.oct_val) * 10 + int'(c - 8'h30);
                sc.oct_val  = (v > 256) ? 9'd256 : 9'(v);
                sc.oct_digs = bump7(sc.oct_digs);
                sc.part_len = bump7(sc.part_len);
            end
            CC_HEXLET: begin
                sc.part_alpha = 1'b1;
                sc.part_len   = bump7(sc.part_len);
            end
            CC_DOT: begin
                if (!octet_good()) sc.addr_bad = 1'b1;
                sc.oct_cnt  = bump7(sc.oct_cnt);
                sc.part_dot = 1'b1;
                sc.oct_val  = '0;
                sc.oct_digs = '0;
                sc.part_len = bump7(sc.part_len);
            end
            default: sc.addr_bad = 1'b1;
        endcase
    endfunction

    function automatic void zone_char(input char_class_t cls);
        logic letter;
        letter = (cls == CC_HEXLET || cls == CC_LETTER);
        if (sc.gap_blank) begin
            sc.zone_bad  = 1'b1;
            sc.gap_blank = 1'b0;
        end
        if (sc.zone_len == 5'd0 && !letter) sc.zone_bad = 1'b1;
        if (int'(sc.zone_len) >= ZONE_MAX) sc.zone_bad = 1'b1;
        if (sc.zone_len != 5'd31) sc.zone_len = sc.zone_len + 5'd1;
        if (!(letter || cls == CC_DIGIT || cls == CC_MARK || cls == CC_DOT)) sc.zone_bad = 1'b1;
        if (cls == CC_DOT && sc.zone_dot) sc.zone_bad = 1'b1;
        sc.zone_dot = (cls == CC_DOT);
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        char_class_t cls;
        cls = char_class(c);
        case (sc.phase)
            PH_LEAD: begin
                if (cls == CC_BLANK) return;
                if (cls == CC_PCT) begin
                    sc.phase = PH_ZLEAD;
                    return;
                end
                sc.phase = PH_ADDR;
                address_char(c, cls);
            end
            PH_ADDR: begin
                if (cls == CC_BLANK) begin
                    sc.gap_blank = 1'b1;
                    return;
                end
                if (cls == CC_PCT) begin
                    if (sc.gap_blank) sc.addr_bad = 1'b1;
                    sc.gap_blank = 1'b0;
                    finish_address();
                    sc.phase = PH_ZLEAD;
                    return;
                end
                address_char(c, cls);
            end
            PH_ZLEAD: begin
                if (cls == CC_BLANK) return;
                sc.phase = PH_ZONE;
                zone_char(cls);
            end
            default: begin
                if (cls == CC_BLANK) begin
                    sc.gap_blank = 1'b1;
                    return;
                end
                zone_char(cls);
            end
        endcase
    endfunction

    function automatic logic [1:0] text_verdict();
        if (sc.phase == PH_LEAD) return blank_ok ? VERDICT_VALID : VERDICT_REQUIRED;
        if (sc.phase == PH_ADDR) begin
            finish_address();
            return sc.addr_bad ? VERDICT_BAD_ADDR : VERDICT_VALID;
        end
        if (!sc.body_seen) return VERDICT_BAD_ADDR;
        if (sc.zone_bad || sc.zone_len == 5'd0) return VERDICT_BAD_ZONE;
        return sc.addr_bad ? VERDICT_BAD_ADDR : VERDICT_VALID;
    endfunction

    // end of text: queue the verdict and start over
    function automatic void close_text();
        logic [1:0]   v;
        verdict_rec_t rec;
        v = text_verdict();
        if (pinned_verdict != NONE) v = pinned_verdict[1:0];
        rec.code = v;
        rec.ok   = (v == VERDICT_VALID);
        rec.tag  = texts_done;
        verdict_q.insert(verdict_q.size(), rec);
        texts_done++;
        sc = '0;
        pinned_verdict = NONE;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------
    task automatic flag_error(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic take_result(input logic [7:0] d);
        verdict_rec_t want;
        if (verdict_q.size() == 0) begin
            flag_error($sformatf("verdict %0d with nothing outstanding", d[1:0]));
            return;
        end
        want = verdict_q.pop_front();
        if (d[1:0] !== want.code)
            flag_error($sformatf("text %0d verdict %0d, want %0d", want.tag, d[1:0], want.code));
        if (d[2] !== want.ok)
            flag_error($sformatf("text %0d is_valid %0b, want %0b", want.tag, d[2], want.ok));
        if (d[7:3] !== 5'd0)
            flag_error($sformatf("text %0d padding bits %0h", want.tag, d[7:3]));
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (holds_taken < holds_asked) begin
                stall = LONG_HOLD;
                holds_taken++;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 16);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            take_result(m_tdata);
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic send_item(input logic has, input logic [7:0] c, input logic eot);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= has;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (has || eot) items_sent++;
        if (has) scan_char(c);
        if (eot) close_text();
    endtask

    // whole text; empty text or solo closes with an end-only transaction
    task automatic send_text(input bit alone);
        int n;
        bit solo;
        n    = text_q.size();
        solo = alone || n == 0;
        for (int i = 0; i < n; i++) begin
            if (noise_items && $urandom_range(0, 15) == 0)
                send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            send_item(1'b1, text_q[i], !solo && i == n - 1);
        end
        if (solo) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_accept_blank(input logic v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        blank_ok  = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] blank_byte();
        int b;
        b = $urandom_range(0, 5);
        return (b == 5) ? CH_SPACE : 8'h09 + 8'(b);
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 255));
        return picks[$urandom_range(0, picks.len() - 1)];
    endfunction

    // append one byte to the text under construction
    function automatic void append_byte(input logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    endfunction

    function automatic void add_blanks(input int n);
        repeat (n) append_byte(blank_byte());
    endfunction

    function automatic void add_hex_group();
        int n;
        n = ($urandom_range(0, 29) == 0) ? 5 : $urandom_range(1, 4);
        repeat (n) append_byte(hexset[$urandom_range(0, hexset.len() - 1)]);
    endfunction

    // dotted quad, mostly in range, sometimes zero-padded or too big
    function automatic void add_quad();
        int v;
        for (int i = 0; i < 4; i++) begin
            if (i > 0) append_byte(CH_DOT);
            v = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
            if ($urandom_range(0, 4) == 0) add_text($sformatf("%03d", v));
            else add_text($sformatf("%0d", v));
        end
    endfunction

    // mostly well-formed address, group count occasionally off by one
    function automatic void add_address();
        int  total;
        int  count;
        int  k;
        bit  comp;
        bit  quads;
        int  kinds[$];
        comp  = 1'($urandom_range(0, 1));
        quads = ($urandom_range(0, 3) == 0);
        total = comp ? $urandom_range(0, 7) : 8;
        if ($urandom_range(0, 9) == 0) total = total + (($urandom_range(0, 1) == 1) ? 1 : -1);
        count = 0;
        while (count < total) begin
            if (quads && total - count >= 2 && $urandom_range(0, 1) == 1) begin
                kinds.insert(kinds.size(), 2);
                count += 2;
            end else begin
                kinds.insert(kinds.size(), 1);
                count += 1;
            end
        end
        k = $urandom_range(0, kinds.size());
        for (int i = 0; i < kinds.size(); i++) begin
            if (comp && i == k) add_text("::");
            else if (i > 0) append_byte(CH_COLON);
            if (kinds[i] == 2) add_quad();
            else add_hex_group();
        end
        if (comp && k == kinds.size()) add_text("::");
    endfunction

    function automatic void add_zone();
        int         n;
        logic [7:0] c;
        append_byte(CH_PERCENT);
        if ($urandom_range(0, 3) == 0) add_blanks($urandom_range(1, 2));
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 16) : $urandom_range(1, 8);
        append_byte(lead[$urandom_range(0, lead.len() - 1)]);
        for (int i = 1; i < n; i++) begin
            c = zset[$urandom_range(0, zset.len() - 1)];
            if (c == CH_DOT && text_q[$] == CH_DOT) c = 8'h78;
            append_byte(c);
        end
    endfunction

    // one random edit: insert, drop, overwrite or a blank inside
    function automatic void mangle();
        int pos;
        pos = $urandom_range(0, text_q.size());
        case ($urandom_range(0, 3))
            0: text_q.insert(pos, noise_byte());
            1: if (pos < text_q.size()) text_q.delete(pos);
            2: if (pos < text_q.size()) text_q[pos] = noise_byte();
            default: text_q.insert(pos, blank_byte());
        endcase
    endfunction

    task automatic build_text(output bit alone);
        int kind;
        text_q.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            add_blanks($urandom_range(0, 4));
        end else if (kind == 1) begin
            repeat ($urandom_range(0, 12)) append_byte(noise_byte());
        end else begin
            if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 3));
            add_address();
            if ($urandom_range(0, 2) == 0) add_zone();
            if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 3));
            if (kind < 6) repeat ($urandom_range(1, 2)) mangle();
        end
        alone = ($urandom_range(0, 3) == 0);
    endtask

    // back-to-back short texts while the result side holds off
    task automatic squeeze();
        bit saved;
        saved   = no_idle;
        no_idle = 1'b1;
        holds_asked++;
        repeat (40) begin
            text_q.delete();
            if ($urandom_range(0, 1) == 1) add_text("::1");
            send_text(1'($urandom_range(0, 1)));
        end
        no_idle = saved;
    endtask

    // main sequence
    initial begin
        bit    alone;
        int    target;
        string s;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed texts
        for (int r = 0; r < $size(dir_rows); r++) begin
            if (dir_rows[r].cfg_wr != NONE) write_accept_blank(dir_rows[r].cfg_wr[0]);
            s = dir_rows[r].txt;
            text_q.delete();
            add_text(s);
            pinned_verdict = dir_rows[r].pinned;
            send_text(dir_rows[r].alone);
        end

        // random texts, accept_blank alternating per phase
        noise_items = 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            write_accept_blank(ph[0] ? 1'b0 : 1'b1);
            no_idle = (ph == 2);
            target  = items_sent + PHASE_ITEMS;
            if (ph == 1) squeeze();
            while (items_sent < target) begin
                build_text(alone);
                send_text(alone);
            end
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
